FILE: sv/hslrgba_pkg.sv
// ----------------------------------------------------------------------------
// hslrgba_pkg
// Shared constants and types for the HSL to RGBA converter pipeline.
// ----------------------------------------------------------------------------
package hslrgba_pkg;

	// raw input ranges
	localparam int HUE_FULL   = 5760;   // 360 degrees, 4 fraction bits
	localparam int PCT_FULL   = 1600;   // 100 percent, 4 fraction bits
	localparam int ALPHA_FULL = 4096;
	localparam int HUE_BIAS   = 6 * HUE_FULL; // lifts any 16-bit hue above zero
	localparam int HUE_WRAPS  = 11;     // multiples of HUE_FULL below the biased maximum

	// unit fractions in Q0.16
	localparam int UNIT_ONE   = 65536;
	localparam int UNIT_HALF  = 32768;
	localparam int UNIT_THIRD = 21845;

	// reciprocal multipliers: h = (hm * HUE_RECIP) >> 21, s = (raw * PCT_RECIP) >> 16
	localparam logic [24:0] HUE_RECIP = 25'd23860930;
	localparam logic [21:0] PCT_RECIP = 22'd2684355;

	// clock enables of the per-channel stages
	typedef struct packed {
		logic s4;
		logic s5;
		logic s6;
	} hslrgba_stage_en_t;

endpackage

FILE: sv/hslrgba_channel.sv
// ----------------------------------------------------------------------------
// hslrgba_channel
// Hue-sector ramp and byte scaling of one colour channel, stages 4 to 6.
// ----------------------------------------------------------------------------
module hslrgba_channel (
	input  logic                           clk,
	input  hslrgba_pkg::hslrgba_stage_en_t en,
	input  logic [15:0]                    t_in,
	input  logic [16:0]                    p_in,
	input  logic [16:0]                    q_in,
	input  logic [16:0]                    l_in,
	input  logic                           gray_in,
	output logic [7:0]                     level
);
	import hslrgba_pkg::*;

	typedef enum logic [1:0] {
		SEC_RISE,
		SEC_TOP,
		SEC_FALL,
		SEC_BOTTOM
	} sector_t;

	logic [18:0] t6;
	logic [16:0] t2;
	logic [17:0] t3;
	sector_t     sector;
	logic [16:0] mult;
	logic [16:0] diff;

	sector_t     sector_s4;
	logic [16:0] mult_s4;
	logic [16:0] diff_s4;
	logic [16:0] p_s4;
	logic [16:0] q_s4;
	logic [16:0] l_s4;
	logic        gray_s4;

	logic [33:0] prod;
	logic [17:0] ramp;
	logic [17:0] ramp_sat;
	logic [16:0] chan;
	logic [16:0] chan_s5;

	logic [24:0] scaled;

	// classify the hue position and pick the ramp slope
	always_comb begin
		t6   = 19'(t_in) * 19'd6;
		t2   = {t_in, 1'b0};
		t3   = 18'(t_in) * 18'd3;
		diff = q_in - p_in;
		mult = '0;
		if (t6 < 19'(UNIT_ONE)) begin
			sector = SEC_RISE;
			mult   = 17'(t6);
		end else if (t2 < 17'(UNIT_ONE)) begin
			sector = SEC_TOP;
		end else if (t3 < 18'(2 * UNIT_ONE)) begin
			sector = SEC_FALL;
			mult   = 17'(19'(4 * UNIT_ONE) - t6);
		end else begin
			sector = SEC_BOTTOM;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			sector_s4 <= sector;
			mult_s4   <= mult;
			diff_s4   <= diff;
			p_s4      <= p_in;
			q_s4      <= q_in;
			l_s4      <= l_in;
			gray_s4   <= gray_in;
		end
	end

	always_comb begin
		prod     = 34'(diff_s4) * 34'(mult_s4);
		ramp     = 18'(p_s4) + prod[33:16];
		ramp_sat = (ramp > 18'(UNIT_ONE)) ? 18'(UNIT_ONE) : ramp;
		if (gray_s4) begin
			chan = l_s4;
		end else begin
			case (sector_s4) inside
				SEC_RISE, SEC_FALL: chan = 17'(ramp_sat);
				SEC_TOP:            chan = q_s4;
				default:            chan = p_s4;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			chan_s5 <= chan;
		end
	end

	// scale by 255 and round half up
	assign scaled = 25'(chan_s5) * 25'd255 + 25'(UNIT_HALF);

	always_ff @(posedge clk) begin
		if (en.s6) begin
			level <= scaled[23:16];
		end
	end

endmodule

FILE: sv/hsl_to_rgba_converter_top.sv
// ----------------------------------------------------------------------------
// hsl_to_rgba_converter_top
// HSL plus alpha to 8-bit RGBA conversion, one pixel per clock.
// ----------------------------------------------------------------------------
// The converter takes one pixel per clock and passes it through six
// register stages (hue wrap and clamps, reciprocal scaling to Q0.16, p/q
// formation, sector classification, ramp multiply, byte rounding); each
// holds a valid bit, and a stage advances whenever it is empty or its
// successor advances. Sustained rate is one transaction per cycle
// while m_axis_tready stays high; when the output stalls, empty stages still
// fill, so up to six transactions are held in flight without loss. The ready
// path is combinational: m_axis_tready reaches s_axis_tready through the
// stage enables with no register between them. Input tdata carries
// hue_deg, saturation_pct, lightness_pct and alpha_level, each a signed
// 16-bit field. Hue wraps modulo 360 degrees, saturation and lightness clamp
// to 0..100 percent, alpha clamps to 0..4096. Zero saturation gives a grey.
// There is no state between pixels; reset only empties the pipeline.
// ----------------------------------------------------------------------------
module hsl_to_rgba_converter_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // hue_deg, saturation_pct, lightness_pct, alpha_level
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata   // red, green, blue, alpha_out
);
	import hslrgba_pkg::*;

	// stage valid bits and enables
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;
	hslrgba_stage_en_t chan_en;

	// input fields
	logic [15:0] hue_in, sat_in, light_in, alpha_in;

	// stage 1: wrapped hue and clamped raw values
	logic [17:0] hue_ext;
	logic [17:0] hue_biased;
	logic [16:0] hue_off;
	logic [12:0] hue_mod;
	logic [10:0] sat_clamp, light_clamp;
	logic [12:0] alpha_clamp;
	logic [12:0] hue_mod_s1;
	logic [10:0] sat_s1, light_s1;
	logic [12:0] alpha_s1;

	// stage 2: Q0.16 fractions and alpha byte
	logic [37:0] hue_prod;
	logic [32:0] sat_prod, light_prod;
	logic [20:0] alpha_scaled;
	logic [15:0] h_s2;
	logic [16:0] s_s2, l_s2;
	logic [7:0]  alpha_s2;

	// stage 3: p, q and the three hue offsets
	logic [33:0] ls_prod;
	logic [16:0] ls;
	logic [17:0] q_sum;
	logic [16:0] q_val;
	logic signed [18:0] p_diff;
	logic [16:0] p_val;
	logic [16:0] tr_sum;
	logic [15:0] tr_val, tb_val;
	logic [15:0] t_r_s3, t_g_s3, t_b_s3;
	logic [16:0] q_s3, p_s3, l_s3;
	logic        gray_s3;
	logic [7:0]  alpha_s3;

	// alpha delay through the channel stages
	logic [7:0] alpha_s4, alpha_s5, alpha_s6;
	logic [7:0] red_s6, green_s6, blue_s6;

	// ---- flow control: a stage moves when empty or when its successor moves
	assign en_s6 = !valid_s6 || m_axis_tready;
	assign en_s5 = !valid_s5 || en_s6;
	assign en_s4 = !valid_s4 || en_s5;
	assign en_s3 = !valid_s3 || en_s4;
	assign en_s2 = !valid_s2 || en_s3;
	assign en_s1 = !valid_s1 || en_s2;

	assign s_axis_tready = en_s1;
	assign m_axis_tvalid = valid_s6;

	assign chan_en.s4 = en_s4;
	assign chan_en.s5 = en_s5;
	assign chan_en.s6 = en_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= s_axis_tvalid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
			if (en_s5) valid_s5 <= valid_s4;
			if (en_s6) valid_s6 <= valid_s5;
		end
	end

	// ---- stage 1: wrap hue into 0..5759, clamp the others
	assign hue_in   = s_axis_tdata[15:0];
	assign sat_in   = s_axis_tdata[31:16];
	assign light_in = s_axis_tdata[47:32];
	assign alpha_in = s_axis_tdata[63:48];

	always_comb begin
		hue_ext    = {{2{hue_in[15]}}, hue_in};
		hue_biased = hue_ext + 18'(HUE_BIAS);
		hue_off    = hue_biased[16:0];
		hue_mod    = 13'(hue_off);
		// drop the largest multiple of a full turn that fits
		for (int j = 1; j <= HUE_WRAPS; j++) begin
			if (hue_off >= 17'(j * HUE_FULL)) begin
				hue_mod = 13'(hue_off - 17'(j * HUE_FULL));
			end
		end

		if (sat_in[15])                        sat_clamp = '0;
		else if (sat_in > 16'(PCT_FULL))       sat_clamp = 11'(PCT_FULL);
		else                                   sat_clamp = sat_in[10:0];

		if (light_in[15])                      light_clamp = '0;
		else if (light_in > 16'(PCT_FULL))     light_clamp = 11'(PCT_FULL);
		else                                   light_clamp = light_in[10:0];

		if (alpha_in[15])                      alpha_clamp = '0;
		else if (alpha_in > 16'(ALPHA_FULL))   alpha_clamp = 13'(ALPHA_FULL);
		else                                   alpha_clamp = alpha_in[12:0];
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			hue_mod_s1 <= hue_mod;
			sat_s1     <= sat_clamp;
			light_s1   <= light_clamp;
			alpha_s1   <= alpha_clamp;
		end
	end

	// ---- stage 2: scale to Q0.16 by reciprocal multiplication (exact here)
	assign hue_prod     = 38'(hue_mod_s1) * 38'(HUE_RECIP);
	assign sat_prod     = 33'(sat_s1) * 33'(PCT_RECIP);
	assign light_prod   = 33'(light_s1) * 33'(PCT_RECIP);
	assign alpha_scaled = 21'(alpha_s1) * 21'd255 + 21'(ALPHA_FULL / 2);

	always_ff @(posedge clk) begin
		if (en_s2) begin
			h_s2     <= hue_prod[36:21];
			s_s2     <= sat_prod[32:16];
			l_s2     <= light_prod[32:16];
			alpha_s2 <= alpha_scaled[19:12];
		end
	end

	// ---- stage 3: q and p; l*(1+s) folds into l + l*s
	always_comb begin
		ls_prod = 34'(l_s2) * 34'(s_s2);
		ls      = ls_prod[32:16];
		if (l_s2 < 17'(UNIT_HALF)) q_sum = 18'(l_s2) + 18'(ls);
		else                       q_sum = 18'(l_s2) + 18'(s_s2) - 18'(ls);
		q_val  = q_sum[16:0];
		p_diff = $signed({1'b0, l_s2, 1'b0}) - $signed({2'b00, q_val});
		if (p_diff < 19'sd0)                    p_val = '0;
		else if (p_diff > 19'sd65536)           p_val = 17'(UNIT_ONE);
		else                                    p_val = p_diff[16:0];

		// hue offsets of plus and minus one third, wrapped into the unit
		tr_sum = 17'(h_s2) + 17'(UNIT_THIRD);
		if (tr_sum >= 17'(UNIT_ONE)) tr_val = 16'(tr_sum - 17'(UNIT_ONE));
		else                         tr_val = tr_sum[15:0];
		if (h_s2 < 16'(UNIT_THIRD))  tb_val = 16'(17'(h_s2) + 17'(UNIT_ONE - UNIT_THIRD));
		else                         tb_val = h_s2 - 16'(UNIT_THIRD);
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			t_r_s3   <= tr_val;
			t_g_s3   <= h_s2;
			t_b_s3   <= tb_val;
			q_s3     <= q_val;
			p_s3     <= p_val;
			l_s3     <= l_s2;
			gray_s3  <= (s_s2 == '0);
			alpha_s3 <= alpha_s2;
		end
	end

	// ---- stages 4 to 6: one sector unit per channel
	hslrgba_channel u_red (
		.clk     (clk),
		.en      (chan_en),
		.t_in    (t_r_s3),
		.p_in    (p_s3),
		.q_in    (q_s3),
		.l_in    (l_s3),
		.gray_in (gray_s3),
		.level   (red_s6)
	);

	hslrgba_channel u_green (
		.clk     (clk),
		.en      (chan_en),
		.t_in    (t_g_s3),
		.p_in    (p_s3),
		.q_in    (q_s3),
		.l_in    (l_s3),
		.gray_in (gray_s3),
		.level   (green_s6)
	);

	hslrgba_channel u_blue (
		.clk     (clk),
		.en      (chan_en),
		.t_in    (t_b_s3),
		.p_in    (p_s3),
		.q_in    (q_s3),
		.l_in    (l_s3),
		.gray_in (gray_s3),
		.level   (blue_s6)
	);

	// hold alpha in step with the colour channels
	always_ff @(posedge clk) begin
		if (en_s4) alpha_s4 <= alpha_s3;
		if (en_s5) alpha_s5 <= alpha_s4;
		if (en_s6) alpha_s6 <= alpha_s5;
	end

	assign m_axis_tdata = {alpha_s6, blue_s6, green_s6, red_s6};

	// ---- assertions
	// an empty output stage frees the whole chain
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s6 |-> s_axis_tready)
		else $error("input stalled with an empty output stage");

	// an accepted transaction lands in stage 1
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> valid_s1)
		else $error("accepted transaction lost at stage 1");

	// a held stage keeps its item
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && !en_s3) |=> valid_s3)
		else $error("stalled stage 3 dropped its item");

	// a moving item reaches the channel stages
	a_hand_on: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && en_s4) |=> valid_s4)
		else $error("item lost between stage 3 and stage 4");

endmodule
